// ----- src/bqls_pkg.sv -----
// ----------------------------------------------------------------------------
// bqls_pkg
// Shared types and constants for the biquad with level smoothing.
// ----------------------------------------------------------------------------
package bqls_pkg;

  localparam int WEIGHT_BITS = 16;   // smoothing weight, unsigned Q0.16
  localparam int LVL_FRAC    = 16;   // fraction bits of the smoothed level
  localparam int CFG_IDX_W   = 3;

  localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = 16'd7;

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_FB1    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FB2    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FF0    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FF1    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FF2    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SM_EN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT = 3'd6;

  // Operand pair for the shared multiplier
  typedef enum logic [2:0] {
    MUL_FF0,   // ff0 * x0
    MUL_FF1,   // ff1 * x1
    MUL_FF2,   // ff2 * x2
    MUL_FB1,   // fb1 * -y1
    MUL_FB2,   // fb2 * -y2
    MUL_WLO,   // w * low 16 bits of level delta
    MUL_WHI    // w * high part of level delta
  } mul_sel_e;

  // Accumulator operation
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_INIT,     // load rounding constant of the filter
    ACC_ADD,      // add product register
    ACC_SM_INIT   // level plus rounded low partial product
  } acc_op_e;

  typedef struct packed {
    logic     load_in;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     y_load;
    logic     d_load;
    logic     commit;
  } cmd_t;

  typedef struct packed {
    logic smooth_en;
  } status_t;

endpackage

// ----- src/biquad_with_level_smoothing.sv -----
// ----------------------------------------------------------------------------
// biquad_with_level_smoothing
// The single shared multiplier takes the five taps and two smoothing partials in
// turn, and a new sample is taken only after the previous one has committed.
// Reset: async active low; history and level clear, ff0 goes to unity and the
// other coefficients to zero.
// ----------------------------------------------------------------------------
module biquad_with_level_smoothing #(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // config write port
  input  logic                               cfg_we_i,
  input  logic [bqls_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [((COEF_FRAC_BITS+4 > bqls_pkg::WEIGHT_BITS) ?
                 COEF_FRAC_BITS+4 : bqls_pkg::WEIGHT_BITS)-1:0] cfg_data_i,
  // sample request channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]      sample_i,
  // result request channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]      result_o,
  output logic signed [SAMPLE_BITS-1:0]      filtered_o
);
  import bqls_pkg::*;

  // config data is as wide as the widest register (coefficient or weight)
  localparam int CFG_W = (COEF_FRAC_BITS + 4 > WEIGHT_BITS) ?
                         COEF_FRAC_BITS + 4 : WEIGHT_BITS;

  cmd_t    cmd;
  status_t status;

  // Sequencer. A sample is taken only while idle; the result sits in the
  // datapath's output register, so the next request is taken while the
  // previous result still waits downstream. Completion holds until the
  // output register is free, and history/level commit in that same cycle.
  bqls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath. Sequence per sample:
  //   one tap product per cycle for the five taps, previous product accumulated
  //   then last add, round, shift and saturate to the filter output
  //   smoothing only:
  //   delta = |y| * 2^16 - level
  //   weight times low and high delta parts, summed with rounding
  //   always:
  //   clamp level (smoothing), load output register
  bqls_dp #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .CFG_W          (CFG_W)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sample_i   (sample_i),
    .result_o   (result_o),
    .filtered_o (filtered_o),
    .cmd_i      (cmd),
    .status_o   (status)
  );

endmodule

// ----- src/bqls_ctrl.sv -----
// ----------------------------------------------------------------------------
// bqls_ctrl
// Sequencer: steps the shared multiplier through the filter taps and the
// smoothing update, and owns the request handshakes.
// ----------------------------------------------------------------------------
module bqls_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  bqls_pkg::status_t status_i,
  output bqls_pkg::cmd_t    cmd_o
);
  import bqls_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MAC   = 3'd1;
  localparam logic [2:0] S_LAST  = 3'd2;
  localparam logic [2:0] S_DIFF  = 3'd3;
  localparam logic [2:0] S_SMLO  = 3'd4;
  localparam logic [2:0] S_SMHI  = 3'd5;
  localparam logic [2:0] S_SMADD = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  localparam logic [2:0] LAST_TAP = 3'd4;

  logic [2:0] state_q, state_d;
  logic [2:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;
  logic       in_acc;
  logic       slot_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && (state_q == S_IDLE);
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    cmd_o        = '0;
    cmd_o.mul_sel = MUL_FF0;
    cmd_o.acc_op  = ACC_HOLD;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_o.load_in = 1'b1;
          cmd_o.acc_op  = ACC_INIT;
          cnt_d         = '0;
          state_d       = S_MAC;
        end
      end
      S_MAC: begin
        unique case (cnt_q)
          3'd0:    cmd_o.mul_sel = MUL_FF0;
          3'd1:    cmd_o.mul_sel = MUL_FF1;
          3'd2:    cmd_o.mul_sel = MUL_FF2;
          3'd3:    cmd_o.mul_sel = MUL_FB1;
          default: cmd_o.mul_sel = MUL_FB2;
        endcase
        // product of the previous tap lands in the accumulator
        cmd_o.acc_op = (cnt_q == '0) ? ACC_HOLD : ACC_ADD;
        cnt_d        = cnt_q + 3'd1;
        if (cnt_q == LAST_TAP) begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        cmd_o.y_load = 1'b1;
        state_d      = status_i.smooth_en ? S_DIFF : S_DONE;
      end
      S_DIFF: begin
        cmd_o.d_load = 1'b1;
        state_d      = S_SMLO;
      end
      S_SMLO: begin
        cmd_o.mul_sel = MUL_WLO;
        state_d       = S_SMHI;
      end
      S_SMHI: begin
        cmd_o.mul_sel = MUL_WHI;
        cmd_o.acc_op  = ACC_SM_INIT;
        state_d       = S_SMADD;
      end
      S_SMADD: begin
        cmd_o.acc_op = ACC_ADD;
        state_d      = S_DONE;
      end
      default: begin
        // S_DONE: wait for the output register
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef ASSERT_OFF
  a_accept_starts_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_MAC) && (cnt_q == '0))
    else $error("accepted request did not start the tap sequence");

  a_tap_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MAC) |-> (cnt_q <= LAST_TAP))
    else $error("tap counter out of range");

  a_commit_has_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> slot_free)
    else $error("result committed over an untaken result");

  a_valid_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_DONE))
    else $error("output valid raised outside completion");
`endif

endmodule

// ----- src/bqls_dp.sv -----
// ----------------------------------------------------------------------------
// bqls_dp
// Datapath: config registers, history, shared multiplier, accumulator,
// saturation and the output register.
// ----------------------------------------------------------------------------
module bqls_dp #(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 16,
  parameter int CFG_W          = 20
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bqls_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_W-1:0]                    cfg_data_i,
  input  logic signed [SAMPLE_BITS-1:0]       sample_i,
  output logic signed [SAMPLE_BITS-1:0]       result_o,
  output logic signed [SAMPLE_BITS-1:0]       filtered_o,
  input  bqls_pkg::cmd_t                      cmd_i,
  output bqls_pkg::status_t                   status_o
);
  import bqls_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int F     = COEF_FRAC_BITS;
  localparam int CW    = COEF_FRAC_BITS + 4;
  localparam int LW    = SAMPLE_BITS + LVL_FRAC;
  // delta spans |y| * 2^16 at full scale minus the most negative level
  localparam int DW    = LW + 2;
  localparam int A_W   = (CW > WEIGHT_BITS + 1) ? CW : WEIGHT_BITS + 1;
  localparam int B_W   = (SB + 2 > LVL_FRAC + 1) ? SB + 2 : LVL_FRAC + 1;
  localparam int P_W   = A_W + B_W;
  localparam int ACC_F = CW + SB + 2;
  localparam int ACC_W = (ACC_F > LW + 2) ? ACC_F : LW + 2;

  localparam logic signed [ACC_W-1:0] ACC_HALF =
    {{(ACC_W-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic signed [P_W-1:0] P_HALF =
    {{(P_W-LVL_FRAC){1'b0}}, 1'b1, {(LVL_FRAC-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] SAT_MAX = {{(ACC_W-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN = {{(ACC_W-SB+1){1'b1}}, {(SB-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] LVL_MAX = {{(ACC_W-LW+1){1'b0}}, {(LW-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] LVL_MIN = {{(ACC_W-LW+1){1'b1}}, {(LW-1){1'b0}}};
  localparam logic signed [CW-1:0]    FF0_RESET = {3'b000, 1'b1, {F{1'b0}}};

  // config
  logic signed [CW-1:0]          fb1_q, fb2_q, ff0_q, ff1_q, ff2_q;
  logic                          sm_en_q;
  logic [WEIGHT_BITS-1:0]        weight_q;
  // state
  logic signed [SB-1:0]          x0_q, xh0_q, xh1_q, yh0_q, yh1_q, y0_q;
  logic signed [LW-1:0]          level_q;
  // working registers
  logic signed [P_W-1:0]         prod_q;
  logic signed [ACC_W-1:0]       acc_q, acc_d;
  logic signed [DW-1:0]          d_q;
  logic signed [SB-1:0]          result_q, filtered_q;

  logic signed [A_W-1:0]         mul_a;
  logic signed [B_W-1:0]         mul_b;
  logic signed [ACC_W-1:0]       acc_sum, acc_shr, lvl_clamp;
  logic signed [SB-1:0]          y0_d;
  logic signed [SB:0]            y_ext, y_mag;
  logic signed [DW-1:0]          d_d;
  logic signed [P_W-1:0]         lo_rnd;
  logic signed [LW-1:0]          level_d;
  logic signed [SB-1:0]          result_d;

  assign status_o.smooth_en = sm_en_q;
  assign result_o           = result_q;
  assign filtered_o         = filtered_q;

  // ---- config port ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb1_q    <= '0;
      fb2_q    <= '0;
      ff0_q    <= FF0_RESET;
      ff1_q    <= '0;
      ff2_q    <= '0;
      sm_en_q  <= 1'b0;
      weight_q <= WEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FB1:    fb1_q    <= cfg_data_i[CW-1:0];
        REG_FB2:    fb2_q    <= cfg_data_i[CW-1:0];
        REG_FF0:    ff0_q    <= cfg_data_i[CW-1:0];
        REG_FF1:    ff1_q    <= cfg_data_i[CW-1:0];
        REG_FF2:    ff2_q    <= cfg_data_i[CW-1:0];
        REG_SM_EN:  sm_en_q  <= cfg_data_i[0];
        REG_WEIGHT: weight_q <= cfg_data_i[WEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ---- shared multiplier operands ----
  // feedback taps negate the sample so the accumulator only ever adds
  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_FF0: begin
        mul_a = A_W'(ff0_q);
        mul_b = B_W'(x0_q);
      end
      MUL_FF1: begin
        mul_a = A_W'(ff1_q);
        mul_b = B_W'(xh0_q);
      end
      MUL_FF2: begin
        mul_a = A_W'(ff2_q);
        mul_b = B_W'(xh1_q);
      end
      MUL_FB1: begin
        mul_a = A_W'(fb1_q);
        mul_b = -B_W'(yh0_q);
      end
      MUL_FB2: begin
        mul_a = A_W'(fb2_q);
        mul_b = -B_W'(yh1_q);
      end
      MUL_WLO: begin
        mul_a = A_W'(signed'({1'b0, weight_q}));
        mul_b = B_W'(signed'({1'b0, d_q[LVL_FRAC-1:0]}));
      end
      MUL_WHI: begin
        mul_a = A_W'(signed'({1'b0, weight_q}));
        mul_b = B_W'(signed'(d_q[DW-1:LVL_FRAC]));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // ---- accumulator ----
  assign acc_sum = acc_q + ACC_W'(prod_q);
  assign lo_rnd  = (prod_q + P_HALF) >>> LVL_FRAC;

  always_comb begin
    unique case (cmd_i.acc_op)
      ACC_INIT:    acc_d = ACC_HALF;
      ACC_ADD:     acc_d = acc_sum;
      ACC_SM_INIT: acc_d = ACC_W'(level_q) + ACC_W'(lo_rnd);
      default:     acc_d = acc_q;
    endcase
  end

  // ---- filter output: shift and saturate ----
  assign acc_shr = acc_sum >>> F;

  always_comb begin
    if (acc_shr > SAT_MAX) begin
      y0_d = SAT_MAX[SB-1:0];
    end else if (acc_shr < SAT_MIN) begin
      y0_d = SAT_MIN[SB-1:0];
    end else begin
      y0_d = acc_shr[SB-1:0];
    end
  end

  // ---- level delta: |y0| * 2^16 - level ----
  assign y_ext = (SB+1)'(y0_q);
  assign y_mag = y0_q[SB-1] ? -y_ext : y_ext;
  assign d_d   = DW'(signed'({y_mag, {LVL_FRAC{1'b0}}})) - DW'(level_q);

  // ---- level update and result ----
  always_comb begin
    if (acc_q > LVL_MAX) begin
      lvl_clamp = LVL_MAX;
    end else if (acc_q < LVL_MIN) begin
      lvl_clamp = LVL_MIN;
    end else begin
      lvl_clamp = acc_q;
    end
    if (sm_en_q) begin
      level_d  = lvl_clamp[LW-1:0];
      result_d = lvl_clamp[LW-1:LVL_FRAC];
    end else begin
      // disabled: level tracks the filter output
      level_d  = {y0_q, {LVL_FRAC{1'b0}}};
      result_d = y0_q;
    end
  end

  // ---- state with reset ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xh0_q   <= '0;
      xh1_q   <= '0;
      yh0_q   <= '0;
      yh1_q   <= '0;
      level_q <= '0;
    end else if (cmd_i.commit) begin
      xh1_q   <= xh0_q;
      xh0_q   <= x0_q;
      yh1_q   <= yh0_q;
      yh0_q   <= y0_q;
      level_q <= level_d;
    end
  end

  // ---- working and payload registers ----
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    acc_q  <= acc_d;
    if (cmd_i.load_in) begin
      x0_q <= sample_i;
    end
    if (cmd_i.y_load) begin
      y0_q <= y0_d;
    end
    if (cmd_i.d_load) begin
      d_q <= d_d;
    end
    if (cmd_i.commit) begin
      result_q   <= result_d;
      filtered_q <= y0_q;
    end
  end

endmodule
